### hw/rtl/glob_pattern_matcher_top_assert.svh
// Assertion macros for the glob pattern matcher checker.
// Used by the checker file only; needs no package.
`ifndef GLOB_PATTERN_MATCHER_TOP_ASSERT_SVH
`define GLOB_PATTERN_MATCHER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define GPM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("glob pattern matcher check failed");

// Next-cycle implication, disabled during reset.
`define GPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("glob pattern matcher check failed");

`endif

### hw/rtl/gpm_pkg.sv
// Shared constants and types for the glob pattern matcher.
// No dependencies.
package gpm_pkg;

    localparam int MAX_PATTERN_BYTES = 24;
    localparam int POS_W             = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int LIVE_W            = MAX_PATTERN_BYTES + 1;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 64;
    localparam int PAT_WORDS         = 3;

    // Special pattern bytes
    localparam logic [7:0] CHAR_STAR = 8'h2A;
    localparam logic [7:0] CHAR_ANY  = 8'h3F;
    localparam logic [7:0] CHAR_ESC  = 8'h5C;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MID    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH   = 2'd3;

    // Decoded pattern: one bit per raw position, valid only below len
    typedef struct packed {
        logic [MAX_PATTERN_BYTES-1:0]       start;  // position opens a token
        logic [MAX_PATTERN_BYTES-1:0]       star;   // token is '*'
        logic [MAX_PATTERN_BYTES-1:0]       any;    // token is '?'
        logic [MAX_PATTERN_BYTES-1:0]       esc;    // escaped literal, two bytes
        logic [MAX_PATTERN_BYTES-1:0][7:0]  lit;    // literal byte to compare
        logic [POS_W-1:0]                   len;    // effective raw length
    } pat_t;

endpackage

### hw/rtl/gpm_decode.sv
// Pattern configuration registers and token decoder.
// Depends on gpm_pkg.
module gpm_decode (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [gpm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gpm_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                            busy,
    output gpm_pkg::pat_t                   pat
);
    import gpm_pkg::*;

    logic [POS_W-1:0]                       len_reg;
    logic [PAT_WORDS-1:0][CFG_DATA_W-1:0]   raw_reg;
    logic                                   pend_reg;
    pat_t                                   pat_reg;
    pat_t                                   pat_next;

    logic [MAX_PATTERN_BYTES:0][7:0]        raw;
    logic [POS_W-1:0]                       n_cap;
    logic [POS_W-1:0]                       n;
    logic [MAX_PATTERN_BYTES-1:0]           esc_c;
    logic [MAX_PATTERN_BYTES-1:0]           start_c;

    // Hold configuration registers; flag a decoder reload on every write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            raw_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= cfg_valid;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_LENGTH: len_reg    <= cfg_data[POS_W-1:0];
                    REG_LOW:    raw_reg[0] <= cfg_data;
                    REG_MID:    raw_reg[1] <= cfg_data;
                    REG_HIGH:   raw_reg[2] <= cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    // Decode raw bytes into token masks
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN_BYTES; i++)
        begin
            raw[i] = raw_reg[i / 8][(i % 8) * 8 +: 8];
        end
        raw[MAX_PATTERN_BYTES] = 8'h00;

        // Clamp length, then cut at the first zero byte in range
        n_cap = (len_reg > POS_W'(MAX_PATTERN_BYTES)) ? POS_W'(MAX_PATTERN_BYTES) : len_reg;
        n     = n_cap;
        for (int i = MAX_PATTERN_BYTES - 1; i >= 0; i--)
        begin
            if ((POS_W'(i) < n_cap) && (raw[i] == 8'h00))
            begin
                n = POS_W'(i);
            end
        end

        // Backslash escapes the next byte only if it is special and in range
        for (int i = 0; i < MAX_PATTERN_BYTES; i++)
        begin
            esc_c[i] = (raw[i] == CHAR_ESC) && (POS_W'(i + 1) < n) &&
                       ((raw[i + 1] == CHAR_STAR) || (raw[i + 1] == CHAR_ANY) ||
                        (raw[i + 1] == CHAR_ESC));
        end

        // Token starts: a byte consumed by an escape opens no token
        start_c[0] = (n != '0);
        for (int i = 1; i < MAX_PATTERN_BYTES; i++)
        begin
            start_c[i] = (POS_W'(i) < n) && !(start_c[i - 1] && esc_c[i - 1]);
        end

        for (int i = 0; i < MAX_PATTERN_BYTES; i++)
        begin
            pat_next.start[i] = start_c[i];
            pat_next.star[i]  = start_c[i] && (raw[i] == CHAR_STAR);
            pat_next.any[i]   = start_c[i] && (raw[i] == CHAR_ANY);
            pat_next.esc[i]   = start_c[i] && esc_c[i];
            pat_next.lit[i]   = esc_c[i] ? raw[i + 1] : raw[i];
        end
        pat_next.len = n;
    end

    // Load decoded pattern the cycle after a write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg <= '0;
        end
        else if (pend_reg)
        begin
            pat_reg <= pat_next;
        end
    end

    assign busy = pend_reg;
    assign pat  = pat_reg;

endmodule

### hw/rtl/glob_pattern_matcher_top.sv
// Top level of the glob pattern matcher: handshakes and live-position state.
// Depends on gpm_pkg and gpm_decode.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------
//  input    | in_valid / in_stall        | text_byte, end_of_text
//  result   | out_valid / out_stall      | matched
//  config   | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One input transaction per cycle while the input is not stalled; the
// live-position update is a single combinational carry-style chain over
// the 25 pattern positions. The verdict is in the result register in the
// cycle after an end item is accepted. A configuration write stalls the
// input while the token decoder reloads. Reset leaves an empty pattern
// and only the start live. A held result stalls the input until it is taken.
module glob_pattern_matcher_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      text_byte,
    input  logic                            end_of_text,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            matched,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gpm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gpm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import gpm_pkg::*;

    pat_t                   pat;
    logic                   dec_busy;
    logic                   cfg_acc;
    logic                   in_acc;

    logic [LIVE_W-1:0]      live_reg;
    logic [LIVE_W-1:0]      live_next;
    logic [LIVE_W-1:0]      closed;
    logic [LIVE_W:0]        step;
    logic [MAX_PATTERN_BYTES-1:0] hit;
    logic                   verdict;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   matched_reg;
    logic                   matched_next;

    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign in_stall  = dec_busy || (out_valid_reg && out_stall);
    assign in_acc    = in_valid && !in_stall;

    gpm_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_acc),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (dec_busy),
        .pat       (pat)
    );

    // Close over live stars, then advance every live token by one byte
    always_comb
    begin
        closed[0] = live_reg[0];
        for (int i = 0; i < MAX_PATTERN_BYTES; i++)
        begin
            closed[i + 1] = live_reg[i + 1] || (closed[i] && pat.star[i]);
        end

        step = '0;
        for (int i = 0; i < MAX_PATTERN_BYTES; i++)
        begin
            hit[i] = closed[i] && pat.start[i] && !pat.star[i] &&
                     (pat.any[i] || (pat.lit[i] == text_byte));
            step[i]     = step[i] || (closed[i] && pat.star[i]);
            step[i + 1] = step[i + 1] || (hit[i] && !pat.esc[i]);
            step[i + 2] = step[i + 2] || (hit[i] && pat.esc[i]);
        end

        verdict = closed[pat.len];
    end

    // Restart on configuration writes and after each verdict
    always_comb
    begin
        live_next = live_reg;
        if (cfg_acc)
        begin
            live_next = LIVE_W'(1);
        end
        else if (in_acc)
        begin
            live_next = end_of_text ? LIVE_W'(1) : step[LIVE_W-1:0];
        end
    end

    // Drop a taken result, load a new verdict on an end item
    always_comb
    begin
        out_valid_next = out_valid_reg;
        matched_next   = matched_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (in_acc && end_of_text)
        begin
            out_valid_next = 1'b1;
            matched_next   = verdict;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg      <= LIVE_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            live_reg      <= live_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        matched_reg <= matched_next;
    end

    assign out_valid = out_valid_reg;
    assign matched   = matched_reg;

endmodule

### hw/rtl/gpm_checker.sv
// Port-level checks for the glob pattern matcher, bound to the top level.
// Depends on glob_pattern_matcher_top_assert.svh.
`include "glob_pattern_matcher_top_assert.svh"

module gpm_checker (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_stall,
    input  logic end_of_text,
    input  logic out_valid,
    input  logic out_stall,
    input  logic matched,
    input  logic cfg_valid,
    input  logic cfg_ready
);

    // Result holds while stalled
    `GPM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `GPM_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(matched))

    // Every end transaction yields a verdict next cycle
    `GPM_ASSERT_NEXT(a_end_verdict, clk, rst_n, in_valid && !in_stall && end_of_text, out_valid)

    // A fresh verdict only follows an end transaction
    `GPM_ASSERT_IMPLY(a_verdict_cause, clk, rst_n, $rose(out_valid),
        $past(in_valid && !in_stall && end_of_text))

    // A configuration write blocks input while the decoder reloads
    `GPM_ASSERT_NEXT(a_cfg_stall, clk, rst_n, cfg_valid && cfg_ready, in_stall)

endmodule

bind glob_pattern_matcher_top gpm_checker u_gpm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .end_of_text (end_of_text),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .matched     (matched),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready)
);
